// ----- hdl/x86_modrm_sib_encoder_defines.svh -----
// Assertion macros shared by the encoder checker.
`ifndef X86_MODRM_SIB_ENCODER_DEFINES_SVH
`define X86_MODRM_SIB_ENCODER_DEFINES_SVH

// Check a property on every edge outside reset.
`define X86MSB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Check a property on every edge, reset included.
`define X86MSB_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

// Check a condition on every result item shown at the output.
`define X86MSB_ASSERT_OUT(label, cond, msg) \
    `X86MSB_ASSERT(label, o_m_tvalid |-> (cond), msg)

`endif

// ----- hdl/x86msb_pkg.sv -----
// Types and codes of the ModR/M and SIB encoder.
package x86msb_pkg;

    localparam int IN_W  = 64;
    localparam int OUT_W = 24;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_REG  = 2'd1,
        KIND_MEM  = 2'd2,
        KIND_IMM  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        FORM_REG_RM  = 2'd0,
        FORM_RM_REG  = 2'd1,
        FORM_REG_IMM = 2'd2,
        FORM_OTHER   = 2'd3
    } t_form;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_BAD_RM    = 3'd1,
        ERR_BAD_REG   = 3'd2,
        ERR_ESP_SCALE = 3'd3,
        ERR_BAD_SCALE = 3'd4
    } t_err;

    localparam logic [2:0] REG_ESP = 3'd4;
    localparam logic [2:0] REG_EBP = 3'd5;
    localparam logic [2:0] RM_SIB  = 3'd4;
    localparam logic [2:0] SIB_NO_INDEX = 3'd4;
    localparam logic [2:0] SIB_NO_BASE  = 3'd5;

    localparam logic [1:0] MOD_NODISP = 2'd0;
    localparam logic [1:0] MOD_DISP8  = 2'd1;
    localparam logic [1:0] MOD_DISP32 = 2'd2;
    localparam logic [1:0] MOD_REG    = 2'd3;

    localparam logic [2:0] DISP_NONE = 3'd0;
    localparam logic [2:0] DISP_8    = 3'd1;
    localparam logic [2:0] DISP_32   = 3'd4;

    // Input item, first field in the lowest bits.
    typedef struct packed {
        logic [2:0]  pad;
        logic [3:0]  reg_digit;
        t_form       template_form;
        logic        has_label;
        logic [31:0] displacement;
        logic [3:0]  scale_factor;
        logic [3:0]  index_register;
        logic [3:0]  base_register;
        logic [2:0]  second_register;
        logic [2:0]  first_register;
        t_kind       second_kind;
        t_kind       first_kind;
    } t_req;

    // Result item, first field in the lowest bits.
    typedef struct packed {
        logic        pad;
        t_err        error_code;
        logic [2:0]  disp_bytes;
        logic [7:0]  sib_byte;
        logic        sib_present;
        logic [7:0]  modrm_byte;
    } t_res;

endpackage

// ----- hdl/x86_modrm_sib_encoder.sv -----
// Top level of the 32-bit ModR/M and SIB encoder.
//
// Input stream (i_s_*): one resolved operand description per item, fields
// packed into i_s_tdata from the lowest bit up. Output stream (o_m_*): one
// result item per input item, in order: ModR/M byte, SIB flag and byte,
// displacement size and error code.
//
// An accepted item is held in an input register; the encoder logic between
// that register and the result register is a single pass, so a result
// shows on o_m_tvalid once it moves into the result register and, with
// i_m_tready high, leaves at the next edge. Throughput is one item per
// cycle while the receiver keeps i_m_tready high, set by the two register
// stages each advancing whenever the stage after it is empty or draining.
//
// When the receiver stalls, the result register holds its item and the
// input register takes one more; only then does o_s_tready drop. A
// synchronous reset (i_rst_n low) empties both stages; no item is lost or
// repeated across a stall.
module x86_modrm_sib_encoder (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    // first_kind, second_kind, first_register, second_register,
    // base_register, index_register, scale_factor, displacement,
    // has_label, template_form, reg_digit, zero pad
    input  logic [x86msb_pkg::IN_W-1:0]  i_s_tdata,
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    // modrm_byte, sib_present, sib_byte, disp_bytes, error_code, zero pad
    output logic [x86msb_pkg::OUT_W-1:0] o_m_tdata
);
    import x86msb_pkg::*;

    logic r_in_vld;
    t_req r_in;
    logic r_out_vld;
    t_res r_out;
    t_res n_out;
    logic adv_out;

    logic       any_mem, has_base, has_index, scale_ok, rm_mem, sib_need;
    logic       sb_valid, si_valid, disp8_fits, disp_zero;
    logic [1:0] mod_f, scale_code;
    logic [2:0] reg_f, rm_f, sb, si, disp_n;
    t_kind      rk;
    logic [2:0] rr;
    t_err       err;

    assign adv_out    = r_in_vld && (!r_out_vld || i_m_tready);
    assign o_s_tready = !r_in_vld || adv_out;
    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_s_tready) begin
                r_in_vld <= i_s_tvalid;
            end
            if (adv_out) begin
                r_out_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in <= t_req'(i_s_tdata);
        end
        if (adv_out) begin
            r_out <= n_out;
        end
    end

    always_comb begin
        case (r_in.scale_factor)
            4'd2:    scale_code = 2'd1;
            4'd4:    scale_code = 2'd2;
            4'd8:    scale_code = 2'd3;
            default: scale_code = 2'd0;
        endcase
    end

    always_comb begin
        any_mem    = (r_in.first_kind == KIND_MEM) || (r_in.second_kind == KIND_MEM);
        has_base   = !r_in.base_register[3];
        has_index  = !r_in.index_register[3];
        scale_ok   = r_in.scale_factor inside {4'd0, 4'd1, 4'd2, 4'd4, 4'd8};
        disp_zero  = (r_in.displacement == 32'd0);
        disp8_fits = (&r_in.displacement[31:7]) || !(|r_in.displacement[31:7]);
        err        = ERR_NONE;
        reg_f      = 3'd0;
        rm_f       = 3'd0;
        rm_mem     = 1'b0;
        sb         = r_in.base_register[2:0];
        si         = r_in.index_register[2:0];
        sb_valid   = has_base;
        si_valid   = has_index;
        sib_need   = 1'b0;

        if (any_mem && !scale_ok) begin
            err = ERR_BAD_SCALE;
        end

        // mod choice before the SIB fixups
        if (r_in.first_kind == KIND_REG &&
            r_in.second_kind inside {KIND_REG, KIND_IMM, KIND_NONE}) begin
            mod_f = MOD_REG;    disp_n = DISP_NONE;
        end else if (!has_base) begin
            mod_f = MOD_NODISP; disp_n = DISP_32;
        end else if (r_in.has_label && disp_zero) begin
            mod_f = MOD_DISP32; disp_n = DISP_32;
        end else if (disp_zero) begin
            mod_f = MOD_NODISP; disp_n = DISP_NONE;
        end else if (disp8_fits) begin
            mod_f = MOD_DISP8;  disp_n = DISP_8;
        end else begin
            mod_f = MOD_DISP32; disp_n = DISP_32;
        end

        if (!r_in.reg_digit[3]) begin
            reg_f = r_in.reg_digit[2:0];
        end else if (r_in.template_form == FORM_RM_REG) begin
            reg_f = r_in.second_register;
        end else if (r_in.template_form == FORM_OTHER) begin
            if (err == ERR_NONE) err = ERR_BAD_REG;
        end else begin
            reg_f = r_in.first_register;
        end

        if (r_in.template_form == FORM_REG_RM) begin
            rk = r_in.second_kind;
            rr = r_in.second_register;
        end else begin
            rk = r_in.first_kind;
            rr = r_in.first_register;
        end
        if (rk == KIND_MEM) begin
            rm_mem = 1'b1;
            rm_f   = has_base ? r_in.base_register[2:0] : REG_EBP;
        end else if (rk == KIND_REG) begin
            rm_f = rr;
        end else if (err == ERR_NONE) begin
            err = ERR_BAD_RM;
        end

        sib_need = (err == ERR_NONE) && rm_mem &&
                   (r_in.scale_factor != 4'd0 || has_index ||
                    (has_base && (sb == REG_ESP || sb == REG_EBP)));

        if (sib_need) begin
            rm_f = RM_SIB;
            // EBP base has no mod 0 form: use a zero disp8
            if (has_base && sb == REG_EBP && mod_f == MOD_NODISP) begin
                mod_f = MOD_DISP8; disp_n = DISP_8;
            end
            if (has_index && si == REG_ESP) begin
                if (r_in.scale_factor != 4'd1) begin
                    err = ERR_ESP_SCALE;
                end else begin
                    // swap the unscaled ESP index into the base slot
                    si       = sb;
                    si_valid = sb_valid;
                    if (!sb_valid) begin
                        mod_f = MOD_DISP32; disp_n = DISP_32;
                    end
                    sb       = REG_ESP;
                    sb_valid = 1'b1;
                end
            end
            if (!sb_valid) begin
                sb = SIB_NO_BASE; mod_f = MOD_NODISP; disp_n = DISP_32;
            end
            if (!si_valid) begin
                si = SIB_NO_INDEX;
            end
        end

        n_out.pad = 1'b0;
        if (err != ERR_NONE) begin
            n_out.modrm_byte  = 8'd0;
            n_out.sib_present = 1'b0;
            n_out.sib_byte    = 8'd0;
            n_out.disp_bytes  = DISP_NONE;
            n_out.error_code  = err;
        end else begin
            n_out.modrm_byte  = {mod_f, reg_f, rm_f};
            n_out.sib_present = sib_need;
            n_out.sib_byte    = sib_need ? {scale_code, si, sb} : 8'd0;
            n_out.disp_bytes  = disp_n;
            n_out.error_code  = ERR_NONE;
        end
    end

endmodule

// ----- hdl/x86msb_checker.sv -----
// Port-level checker for the ModR/M and SIB encoder, with its bind.
`include "x86_modrm_sib_encoder_defines.svh"

module x86msb_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_m_tvalid,
    input logic                         i_m_tready,
    input logic [x86msb_pkg::OUT_W-1:0] o_m_tdata
);
    import x86msb_pkg::*;

    t_res       res;
    logic [1:0] res_mod;
    logic       err_clean;
    logic       sib_rm;
    logic       disp_match;

    assign res     = t_res'(o_m_tdata);
    assign res_mod = res.modrm_byte[7:6];

    assign err_clean = (res.error_code == ERR_NONE) ||
                       (res.modrm_byte == 8'd0 && !res.sib_present &&
                        res.sib_byte == 8'd0 && res.disp_bytes == DISP_NONE);
    assign sib_rm = !res.sib_present ||
                    (res.modrm_byte[2:0] == RM_SIB && res_mod != MOD_REG);
    assign disp_match = (res.error_code != ERR_NONE) ||
                        (res_mod == MOD_REG && res.disp_bytes == DISP_NONE) ||
                        (res_mod == MOD_DISP8 && res.disp_bytes == DISP_8) ||
                        (res_mod == MOD_DISP32 && res.disp_bytes == DISP_32) ||
                        (res_mod == MOD_NODISP &&
                         (res.disp_bytes == DISP_NONE || res.disp_bytes == DISP_32));

    // An error item carries no encoding.
    `X86MSB_ASSERT_OUT(a_err_clean, err_clean, "error item with nonzero encoding")
    // A SIB byte always goes with r/m 4 and a memory mod.
    `X86MSB_ASSERT_OUT(a_sib_rm, sib_rm, "SIB without r/m 4")
    // Displacement size follows mod, except the no-base forms with mod 0.
    `X86MSB_ASSERT_OUT(a_disp_mod, disp_match, "disp size does not match mod")
    // A stalled result holds.
    `X86MSB_ASSERT(a_hold, (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)), "stalled result changed")
    // Reset empties the output.
    `X86MSB_ASSERT_ALWAYS(a_reset, !i_rst_n |=> !o_m_tvalid, "output valid after reset")

endmodule

bind x86_modrm_sib_encoder x86msb_checker u_x86msb_checker (.*);

// ----- test/x86_modrm_sib_encoder_check.sv -----
// Checker for the ModR/M and SIB encoder: predicts every result item and compares it.
`timescale 1ns / 100ps

module x86_modrm_sib_encoder_check (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    input  logic                         i_s_tready,
    // first_kind, second_kind, first_register, second_register,
    // base_register, index_register, scale_factor, displacement,
    // has_label, template_form, reg_digit, zero pad
    input  logic [x86msb_pkg::IN_W-1:0]  i_s_tdata,
    input  logic                         i_m_tvalid,
    input  logic                         i_m_tready,
    // modrm_byte, sib_present, sib_byte, disp_bytes, error_code, zero pad
    input  logic [x86msb_pkg::OUT_W-1:0] i_m_tdata,
    output int                           o_fail_count,
    output int                           o_pending
);
    import x86msb_pkg::*;

    t_res encodings_due[$];
    t_res got_enc;
    t_res want_enc;
    int   fail_count = 0;
    int   pending_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending = pending_count;

    function automatic t_res encode_operand(input t_req r);
        logic        has_base;
        logic        has_index;
        logic        rm_mem;
        logic        sb_valid;
        logic        si_valid;
        logic [1:0]  mod_f;
        logic [1:0]  scale_code;
        logic [2:0]  reg_f;
        logic [2:0]  rm_f;
        logic [2:0]  rm_reg;
        logic [2:0]  disp;
        logic [2:0]  sb;
        logic [2:0]  si;
        logic [31:0] disp_biased;
        t_kind       rm_kind;
        t_err        err;
        t_res        res;

        has_base = !r.base_register[3];
        has_index = !r.index_register[3];
        rm_mem = 1'b0;
        reg_f = 3'd0;
        rm_f = 3'd0;
        disp = DISP_NONE;
        err = ERR_NONE;
        res = '0;

        case (r.scale_factor)
            4'd2: scale_code = 2'd1;
            4'd4: scale_code = 2'd2;
            4'd8: scale_code = 2'd3;
            default: scale_code = 2'd0;
        endcase
        case (r.scale_factor)
            4'd0, 4'd1, 4'd2, 4'd4, 4'd8: ;
            default: begin
                if (r.first_kind == KIND_MEM || r.second_kind == KIND_MEM)
                    err = ERR_BAD_SCALE;
            end
        endcase

        disp_biased = r.displacement + 32'd128;
        if (r.first_kind == KIND_REG && r.second_kind != KIND_MEM) begin
            mod_f = MOD_REG;
        end else if (!has_base) begin
            mod_f = MOD_NODISP;
            disp = DISP_32;
        end else if (r.has_label && r.displacement == 32'd0) begin
            mod_f = MOD_DISP32;
            disp = DISP_32;
        end else if (r.displacement == 32'd0) begin
            mod_f = MOD_NODISP;
        end else if (disp_biased < 32'd256) begin
            mod_f = MOD_DISP8;
            disp = DISP_8;
        end else begin
            mod_f = MOD_DISP32;
            disp = DISP_32;
        end

        if (!r.reg_digit[3]) begin
            reg_f = r.reg_digit[2:0];
        end else if (r.template_form == FORM_RM_REG) begin
            reg_f = r.second_register;
        end else if (r.template_form == FORM_OTHER) begin
            if (err == ERR_NONE) err = ERR_BAD_REG;
        end else begin
            reg_f = r.first_register;
        end

        if (r.template_form == FORM_REG_RM) begin
            rm_kind = r.second_kind;
            rm_reg = r.second_register;
        end else begin
            rm_kind = r.first_kind;
            rm_reg = r.first_register;
        end
        if (rm_kind == KIND_MEM) begin
            rm_mem = 1'b1;
            rm_f = has_base ? r.base_register[2:0] : SIB_NO_BASE;
        end else if (rm_kind == KIND_REG) begin
            rm_f = rm_reg;
        end else if (err == ERR_NONE) begin
            err = ERR_BAD_RM;
        end

        if (err == ERR_NONE && rm_mem && (r.scale_factor != 4'd0 || has_index ||
                (has_base && (r.base_register[2:0] == REG_ESP ||
                              r.base_register[2:0] == REG_EBP)))) begin
            sb = r.base_register[2:0];
            si = r.index_register[2:0];
            sb_valid = has_base;
            si_valid = has_index;
            rm_f = RM_SIB;
            res.sib_present = 1'b1;
            if (has_base && sb == REG_EBP && mod_f == MOD_NODISP) begin
                mod_f = MOD_DISP8;
                disp = DISP_8;
            end
            // ESP cannot be an index: swap it into the base when unscaled
            if (has_index && si == REG_ESP) begin
                if (r.scale_factor != 4'd1) begin
                    err = ERR_ESP_SCALE;
                end else begin
                    si = sb;
                    si_valid = sb_valid;
                    if (!sb_valid) begin
                        mod_f = MOD_DISP32;
                        disp = DISP_32;
                    end
                    sb = REG_ESP;
                    sb_valid = 1'b1;
                end
            end
            if (!sb_valid) begin
                sb = SIB_NO_BASE;
                mod_f = MOD_NODISP;
                disp = DISP_32;
            end
            if (!si_valid) si = SIB_NO_INDEX;
            res.sib_byte = {scale_code, si, sb};
        end

        if (err != ERR_NONE) begin
            res = '0;
            res.error_code = err;
        end else begin
            res.modrm_byte = {mod_f, reg_f, rm_f};
            res.disp_bytes = disp;
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && i_s_tready)
                encodings_due.push_back(encode_operand(t_req'(i_s_tdata)));
            if (i_m_tvalid && i_m_tready) begin
                got_enc = t_res'(i_m_tdata);
                if (encodings_due.size() == 0) begin
                    if (fail_count < 10)
                        $display("%0t: result item with none outstanding: %06h",
                                 $time, i_m_tdata);
                    fail_count++;
                end else begin
                    want_enc = encodings_due.pop_front();
                    if (got_enc.modrm_byte != want_enc.modrm_byte ||
                            got_enc.sib_present != want_enc.sib_present ||
                            got_enc.sib_byte != want_enc.sib_byte ||
                            got_enc.disp_bytes != want_enc.disp_bytes ||
                            got_enc.error_code != want_enc.error_code) begin
                        if (fail_count < 10)
                            $display({"%0t: mismatch: expected modrm %02h sib %0d/%02h ",
                                      "disp %0d err %0d, got modrm %02h sib %0d/%02h ",
                                      "disp %0d err %0d"}, $time,
                                     want_enc.modrm_byte, want_enc.sib_present,
                                     want_enc.sib_byte, want_enc.disp_bytes,
                                     want_enc.error_code, got_enc.modrm_byte,
                                     got_enc.sib_present, got_enc.sib_byte,
                                     got_enc.disp_bytes, got_enc.error_code);
                        fail_count++;
                    end
                end
            end
            pending_count = encodings_due.size();
        end
    end

endmodule

// ----- test/x86_modrm_sib_encoder_test.sv -----
// Testbench top for the ModR/M and SIB encoder: stimulus, flow control and verdict.
`timescale 1ns / 100ps

module x86_modrm_sib_encoder_test;
    import x86msb_pkg::*;

    localparam int          RESET_CYCLES = 7;
    localparam int          RANDOM_ITEMS = 1100;
    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          DRAIN_CYCLES = 20;
    localparam logic [3:0]  NO_REG       = 4'd8;
    localparam logic [3:0]  FROM_OPS     = 4'd8;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_s_tvalid = 1'b0;
    logic [IN_W-1:0]   i_s_tdata = '0;
    logic              i_m_tready = 1'b0;
    logic              o_s_tready;
    logic              o_m_tvalid;
    logic [OUT_W-1:0]  o_m_tdata;
    int                fail_count;
    int                pending_count;
    int                cycle_count = 0;
    int                tx_gap_max = 19;
    int                rx_hold_cycles = 0;

    x86_modrm_sib_encoder u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    x86_modrm_sib_encoder_check u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic send_item(input t_req item);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= item;
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    task automatic send_fields(input t_kind fk, input t_kind sk, input logic [2:0] fr,
                               input logic [2:0] sr, input logic [3:0] base,
                               input logic [3:0] idx, input logic [3:0] scale,
                               input logic [31:0] disp, input logic label,
                               input t_form form, input logic [3:0] digit);
        t_req item;
        item = '0;
        item.first_kind = fk;
        item.second_kind = sk;
        item.first_register = fr;
        item.second_register = sr;
        item.base_register = base;
        item.index_register = idx;
        item.scale_factor = scale;
        item.displacement = disp;
        item.has_label = label;
        item.template_form = form;
        item.reg_digit = digit;
        send_item(item);
    endtask

    // Mostly well-formed memory operands with random content, the rest pure noise.
    function automatic t_req random_operand();
        t_req r;
        r = t_req'({$urandom, $urandom});
        r.pad = '0;
        if ($urandom_range(0, 9) < 7) begin
            case ($urandom_range(0, 2))
                0: begin
                    r.template_form = FORM_REG_RM;
                    r.first_kind = KIND_REG;
                    r.second_kind = KIND_MEM;
                end
                1: begin
                    r.template_form = FORM_RM_REG;
                    r.first_kind = KIND_MEM;
                    r.second_kind = KIND_REG;
                end
                default: begin
                    r.template_form = FORM_REG_IMM;
                    r.first_kind = KIND_MEM;
                    r.second_kind = $urandom_range(0, 1) ? KIND_IMM : KIND_NONE;
                end
            endcase
            r.reg_digit = $urandom_range(0, 1) ? FROM_OPS : 4'($urandom_range(0, 7));
            r.base_register = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(8, 15))
                                                          : 4'($urandom_range(0, 7));
            r.index_register = $urandom_range(0, 1) ? 4'($urandom_range(8, 15))
                                                    : 4'($urandom_range(0, 7));
            case ($urandom_range(0, 5))
                0: r.scale_factor = 4'd0;
                1: r.scale_factor = 4'd1;
                2: r.scale_factor = 4'd2;
                3: r.scale_factor = 4'd4;
                4: r.scale_factor = 4'd8;
                default: ;
            endcase
            case ($urandom_range(0, 3))
                0: r.displacement = 32'd0;
                1: r.displacement = 32'($urandom_range(0, 255)) - 32'd128;
                2: begin
                    case ($urandom_range(0, 3))
                        0: r.displacement = 32'd127;
                        1: r.displacement = 32'd128;
                        2: r.displacement = 32'hFFFF_FF80;
                        default: r.displacement = 32'hFFFF_FF7F;
                    endcase
                end
                default: ;
            endcase
        end
        return r;
    endfunction

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // register direct, register with immediate
        send_fields(KIND_REG, KIND_REG, 3'd0, 3'd7, NO_REG, NO_REG, 4'd0, 32'd0, 1'b0,
                    FORM_REG_RM, FROM_OPS);
        send_fields(KIND_REG, KIND_IMM, 3'd7, 3'd0, 4'd3, NO_REG, 4'd0, 32'd0, 1'b1,
                    FORM_REG_IMM, FROM_OPS);
        // mod choice: no base, label at zero, zero, byte and word boundaries
        send_fields(KIND_REG, KIND_MEM, 3'd2, 3'd0, NO_REG, NO_REG, 4'd0, 32'h1234_5678,
                    1'b0, FORM_REG_RM, FROM_OPS);
        send_fields(KIND_REG, KIND_MEM, 3'd1, 3'd0, 4'd3, NO_REG, 4'd0, 32'd0, 1'b1,
                    FORM_REG_RM, FROM_OPS);
        send_fields(KIND_REG, KIND_MEM, 3'd1, 3'd0, 4'd3, NO_REG, 4'd0, 32'd0, 1'b0,
                    FORM_REG_RM, FROM_OPS);
        send_fields(KIND_REG, KIND_MEM, 3'd3, 3'd0, 4'd6, NO_REG, 4'd0, 32'd127, 1'b0,
                    FORM_REG_RM, FROM_OPS);
        send_fields(KIND_REG, KIND_MEM, 3'd3, 3'd0, 4'd7, NO_REG, 4'd0, 32'hFFFF_FF80,
                    1'b1, FORM_REG_RM, FROM_OPS);
        send_fields(KIND_REG, KIND_MEM, 3'd4, 3'd0, 4'd0, NO_REG, 4'd0, 32'd128, 1'b0,
                    FORM_REG_RM, FROM_OPS);
        send_fields(KIND_REG, KIND_MEM, 3'd5, 3'd0, 4'd1, NO_REG, 4'd0, 32'hFFFF_FF7F,
                    1'b0, FORM_REG_RM, FROM_OPS);
        send_fields(KIND_REG, KIND_MEM, 3'd6, 3'd0, 4'd2, NO_REG, 4'd0, 32'h7FFF_FFFF,
                    1'b0, FORM_REG_RM, FROM_OPS);
        send_fields(KIND_REG, KIND_MEM, 3'd7, 3'd0, 4'd6, NO_REG, 4'd0, 32'h8000_0000,
                    1'b1, FORM_REG_RM, FROM_OPS);
        // ESP and EBP bases force a SIB byte; EBP with no displacement goes to disp8
        send_fields(KIND_MEM, KIND_REG, 3'd0, 3'd2, 4'd4, NO_REG, 4'd0, 32'd0, 1'b0,
                    FORM_RM_REG, FROM_OPS);
        send_fields(KIND_MEM, KIND_REG, 3'd0, 3'd3, 4'd5, NO_REG, 4'd0, 32'd0, 1'b0,
                    FORM_RM_REG, FROM_OPS);
        // ESP index: swap when unscaled, with and without a base, error when scaled
        send_fields(KIND_MEM, KIND_IMM, 3'd0, 3'd0, 4'd3, 4'd4, 4'd1, 32'd16, 1'b0,
                    FORM_REG_IMM, 4'd2);
        send_fields(KIND_MEM, KIND_IMM, 3'd0, 3'd0, NO_REG, 4'd4, 4'd1, 32'd0, 1'b0,
                    FORM_REG_IMM, 4'd0);
        send_fields(KIND_MEM, KIND_NONE, 3'd0, 3'd0, 4'd3, 4'd4, 4'd2, 32'd0, 1'b0,
                    FORM_REG_IMM, 4'd0);
        // no base with scaled index, and registers, scale, displacement and digit at their top
        send_fields(KIND_REG, KIND_MEM, 3'd6, 3'd0, NO_REG, 4'd2, 4'd4, 32'd0, 1'b0,
                    FORM_REG_RM, FROM_OPS);
        send_fields(KIND_MEM, KIND_REG, 3'd7, 3'd7, 4'd7, 4'd7, 4'd8, 32'hFFFF_FFFF, 1'b1,
                    FORM_RM_REG, 4'd15);
        // scale codes: invalid with memory, ignored without
        send_fields(KIND_REG, KIND_MEM, 3'd1, 3'd1, 4'd1, 4'd1, 4'd3, 32'd4, 1'b0,
                    FORM_REG_RM, FROM_OPS);
        send_fields(KIND_REG, KIND_REG, 3'd5, 3'd6, 4'd15, 4'd15, 4'd15, 32'd9, 1'b0,
                    FORM_REG_RM, FROM_OPS);
        // other template: needs a fixed digit
        send_fields(KIND_MEM, KIND_NONE, 3'd0, 3'd0, 4'd0, NO_REG, 4'd0, 32'd0, 1'b0,
                    FORM_OTHER, FROM_OPS);
        send_fields(KIND_MEM, KIND_NONE, 3'd0, 3'd0, 4'd0, 4'd15, 4'd0, 32'd0, 1'b0,
                    FORM_OTHER, 4'd7);
        // r/m operand that is neither register nor memory
        send_fields(KIND_MEM, KIND_NONE, 3'd0, 3'd0, 4'd2, NO_REG, 4'd0, 32'd0, 1'b0,
                    FORM_REG_RM, FROM_OPS);
        send_fields(KIND_IMM, KIND_REG, 3'd4, 3'd4, 4'd2, NO_REG, 4'd0, 32'd0, 1'b0,
                    FORM_REG_IMM, 4'd15);
        // bad scale outranks bad reg and bad r/m
        send_fields(KIND_NONE, KIND_MEM, 3'd0, 3'd0, 4'd2, 4'd2, 4'd9, 32'd0, 1'b0,
                    FORM_OTHER, FROM_OPS);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 450) rx_hold_cycles = 150;
            if (n >= 450 && n < 520) begin
                tx_gap_max = 0;
            end else begin
                case ((n / 100) % 3)
                    0: tx_gap_max = 19;
                    1: tx_gap_max = 0;
                    default: tx_gap_max = 3;
                endcase
            end
            send_item(random_operand());
        end
        i_s_tvalid <= 1'b0;

        do @(negedge i_clk); while (pending_count != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        if (fail_count == 0 && pending_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        int stall;
        int taken;
        taken = 0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (rx_hold_cycles > 0) begin
                stall = rx_hold_cycles;
                rx_hold_cycles = 0;
            end else begin
                case ((taken / 150) % 3)
                    0: stall = $urandom_range(0, 19);
                    1: stall = 0;
                    default: stall = $urandom_range(0, 3);
                endcase
            end
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
            taken++;
        end
    end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/x86msb_pkg.sv
hdl/x86_modrm_sib_encoder.sv
hdl/x86msb_checker.sv
test/x86_modrm_sib_encoder_check.sv
test/x86_modrm_sib_encoder_test.sv
